@@ rtl/rme_pkg.sv @@
// ----------------------------------------------------------------------------
// rme_pkg
// Shared widths, codes and types of the modular exponentiation block.
// ----------------------------------------------------------------------------
package rme_pkg;

	localparam int VAL_W = 32;
	localparam int WIDTH = 32;
	localparam int CNT_W = $clog2(WIDTH + 1);
	localparam int IDX_W = 2;

	localparam logic [IDX_W-1:0] REG_MODULUS    = 2'd0;
	localparam logic [IDX_W-1:0] REG_PUBLIC_EXP = 2'd1;
	localparam logic [IDX_W-1:0] REG_PRIVATE_EXP = 2'd2;

	typedef enum logic [2:0] {
		EX_IDLE,
		EX_REDUCE,
		EX_SQUARE,
		EX_MULT,
		EX_DONE
	} ex_state_t;

	typedef struct packed {
		logic             start;
		logic [WIDTH-1:0] a;
		logic [WIDTH-1:0] b;
		logic [WIDTH-1:0] n;
	} mm_cmd_t;

	typedef struct packed {
		logic idle;
		logic done;
	} ex_stat_t;

endpackage

@@ rtl/rsa_modular_exponentiation.sv @@
// ----------------------------------------------------------------------------
// rsa_modular_exponentiation
// Modular exponentiation of one value per beat with the public or private
// exponent, using bit-serial modular multiplies.
// ----------------------------------------------------------------------------
// channel  direction  handshake             payload
// in       input      in_valid / in_stall   mode, message_value
// out      output     out_valid / out_stall residue
// cfg      input      wr_en                 wr_index, wr_data
//
// A modulus below 2 gives 0 without a multiply. One item is in flight at a
// time; the output register frees the sequencer while a result waits on
// out_stall. Reset loads modulus 2 and both exponents 1.
// ----------------------------------------------------------------------------
module rsa_modular_exponentiation
	import rme_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic             mode,
	input  logic [VAL_W-1:0] message_value,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [VAL_W-1:0] residue,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_index,
	input  logic [VAL_W-1:0] wr_data
);

	logic [VAL_W-1:0] modulus_q;
	logic [VAL_W-1:0] public_exp_q;
	logic [VAL_W-1:0] private_exp_q;
	logic             out_valid_q;
	logic [VAL_W-1:0] residue_q;

	ex_stat_t         ex_stat;
	logic [WIDTH-1:0] ex_result;
	logic             accept;
	logic             ack;
	logic [WIDTH-1:0] exp_sel;

	assign in_stall = !ex_stat.idle;
	assign accept   = in_valid && !in_stall;
	assign ack      = ex_stat.done && (!out_valid_q || !out_stall);
	assign exp_sel  = mode ? private_exp_q[WIDTH-1:0] : public_exp_q[WIDTH-1:0];

	rme_expo u_expo (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (accept),
		.base_in (message_value[WIDTH-1:0]),
		.exp_in  (exp_sel),
		.n_in    (modulus_q[WIDTH-1:0]),
		.ack     (ack),
		.stat    (ex_stat),
		.result  (ex_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q     <= VAL_W'(2);
			public_exp_q  <= VAL_W'(1);
			private_exp_q <= VAL_W'(1);
		end else if (wr_en) begin
			unique case (wr_index)
				REG_MODULUS:     modulus_q     <= wr_data;
				REG_PUBLIC_EXP:  public_exp_q  <= wr_data;
				REG_PRIVATE_EXP: private_exp_q <= wr_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ack) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ack) residue_q <= VAL_W'(ex_result);
	end

	assign out_valid = out_valid_q;
	assign residue   = residue_q;

endmodule

@@ rtl/rme_mulmod.sv @@
// ----------------------------------------------------------------------------
// rme_mulmod
// Bit-serial modular multiplier: a * b mod n, one bit of b per cycle.
// ----------------------------------------------------------------------------
module rme_mulmod
	import rme_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  mm_cmd_t          cmd,
	output logic             done,
	output logic [WIDTH-1:0] prod
);

	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [WIDTH-1:0] p_q;
	logic [WIDTH-1:0] a_q;
	logic [WIDTH-1:0] b_q;
	logic [WIDTH-1:0] n_q;

	logic [WIDTH:0]   dbl;
	logic [WIDTH:0]   dbl_sub;
	logic [WIDTH-1:0] dbl_red;
	logic [WIDTH:0]   add;
	logic [WIDTH:0]   add_sub;
	logic [WIDTH-1:0] p_next;

	always_comb begin
		dbl     = {p_q, 1'b0};
		dbl_sub = dbl - {1'b0, n_q};
		dbl_red = (dbl >= {1'b0, n_q}) ? dbl_sub[WIDTH-1:0] : dbl[WIDTH-1:0];
		add     = {1'b0, dbl_red} + (b_q[WIDTH-1] ? {1'b0, a_q} : '0);
		add_sub = add - {1'b0, n_q};
		p_next  = (add >= {1'b0, n_q}) ? add_sub[WIDTH-1:0] : add[WIDTH-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CNT_W'(1));
			if (cmd.start && cnt_q == '0) begin
				cnt_q <= CNT_W'(WIDTH);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start && cnt_q == '0) begin
			p_q <= '0;
			a_q <= cmd.a;
			b_q <= cmd.b;
			n_q <= cmd.n;
		end else if (cnt_q != '0) begin
			p_q <= p_next;
			b_q <= {b_q[WIDTH-2:0], 1'b0};
		end
	end

	assign done = done_q;
	assign prod = p_q;

endmodule

@@ rtl/rme_expo.sv @@
// ----------------------------------------------------------------------------
// rme_expo
// Square-and-multiply sequencer over the exponent bits, MSB first.
// ----------------------------------------------------------------------------
module rme_expo
	import rme_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [WIDTH-1:0] base_in,
	input  logic [WIDTH-1:0] exp_in,
	input  logic [WIDTH-1:0] n_in,
	input  logic             ack,
	output ex_stat_t         stat,
	output logic [WIDTH-1:0] result
);

	ex_state_t        state_q;
	ex_state_t        state_d;
	logic [CNT_W-1:0] k_q;
	logic [WIDTH-1:0] exp_q;
	logic [WIDTH-1:0] n_q;
	logic [WIDTH-1:0] base_q;
	logic [WIDTH-1:0] res_q;

	mm_cmd_t          mm_cmd;
	logic             mm_done;
	logic [WIDTH-1:0] mm_prod;

	logic             n_small;
	logic             ebit;
	logic             last;

	assign n_small = ~|n_in[WIDTH-1:1];
	assign ebit    = exp_q[WIDTH-1];
	assign last    = (k_q == CNT_W'(1));

	rme_mulmod u_mulmod (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (mm_cmd),
		.done   (mm_done),
		.prod   (mm_prod)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			EX_IDLE: begin
				if (start) state_d = n_small ? EX_DONE : EX_REDUCE;
			end
			EX_REDUCE: begin
				if (mm_done) state_d = EX_SQUARE;
			end
			EX_SQUARE: begin
				if (mm_done) state_d = ebit ? EX_MULT : (last ? EX_DONE : EX_SQUARE);
			end
			EX_MULT: begin
				if (mm_done) state_d = last ? EX_DONE : EX_SQUARE;
			end
			EX_DONE: begin
				if (ack) state_d = EX_IDLE;
			end
			default: state_d = EX_IDLE;
		endcase
	end

	always_comb begin
		mm_cmd.start = 1'b0;
		mm_cmd.a     = mm_prod;
		mm_cmd.b     = mm_prod;
		mm_cmd.n     = n_q;
		unique case (state_q)
			EX_IDLE: begin
				mm_cmd.start = start && !n_small;
				mm_cmd.a     = WIDTH'(1);
				mm_cmd.b     = base_in;
				mm_cmd.n     = n_in;
			end
			EX_REDUCE: begin
				mm_cmd.start = mm_done;
				mm_cmd.a     = WIDTH'(1);
				mm_cmd.b     = WIDTH'(1);
			end
			EX_SQUARE: begin
				mm_cmd.start = mm_done && (ebit || !last);
				mm_cmd.b     = ebit ? base_q : mm_prod;
			end
			EX_MULT: begin
				mm_cmd.start = mm_done && !last;
			end
			EX_DONE: begin
				mm_cmd.start = 1'b0;
			end
			default: mm_cmd.start = 1'b0;
		endcase
		stat.idle = (state_q == EX_IDLE);
		stat.done = (state_q == EX_DONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= EX_IDLE;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == EX_IDLE && start) begin
				k_q <= CNT_W'(WIDTH);
			end else if (mm_done && ((state_q == EX_SQUARE && !ebit) || state_q == EX_MULT)) begin
				k_q <= k_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == EX_IDLE && start) begin
			n_q   <= n_in;
			exp_q <= exp_in;
			res_q <= '0;
		end else if (state_q == EX_REDUCE && mm_done) begin
			base_q <= mm_prod;
		end else if (mm_done && ((state_q == EX_SQUARE && !ebit) || state_q == EX_MULT)) begin
			exp_q <= {exp_q[WIDTH-2:0], 1'b0};
			if (last) res_q <= mm_prod;
		end
	end

	assign result = res_q;

endmodule
